### rtl/core/pssynth_pkg.sv
// ----------------------------------------------------------------------------
// pssynth_pkg
// Shared types and constants for the plucked-string delay synthesiser.
// ----------------------------------------------------------------------------
package pssynth_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 9;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [DELAY_W-1:0]  delay_t;

  // Item kinds carried on the input tuser bit
  typedef enum logic {
    CMD_EXCITE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // Halve a 17-bit sum, truncating toward zero
  function automatic sample_t avg_trunc(input logic signed [SAMPLE_W:0] sum);
    logic signed [SAMPLE_W:0] adj;
    adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
    return adj[SAMPLE_W:1];
  endfunction

endpackage

### rtl/core/plucked_string_delay_synth.sv
// ----------------------------------------------------------------------------
// plucked_string_delay_synth
// Plucked-string synthesis over a circular sample memory with a delay tap.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one sample per tick item. Each item is
// accepted into a read stage that addresses the sample memory at two ports
// (pointer - delay and pointer - delay - 1); as the read stage advances, its read
// data are averaged, the result (or the excite sample) is written back at the
// pointer and a tick's sample moves to the output register. A tick waiting in
// the read stage behind a held output sample stalls the input until the sink
// takes it. The write of the item ahead is forwarded to the read stage when
// both touch the same entry. After reset the memory is not swept: a fill mark
// (write pointer plus a wrapped flag) makes entries not yet written read as
// zero, so the block accepts items from the first cycle.
module plucked_string_delay_synth #(
  parameter int RING_DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: string_delay
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  pssynth_pkg::delay_t           cfg_data,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] noise_sample
  input  logic                          s_axis_tuser,  // [0] cmd
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // [15:0] out_sample
);
  import pssynth_pkg::*;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int DIFF_W = (PTR_W > DELAY_W) ? PTR_W : DELAY_W;

  typedef logic [PTR_W-1:0] ptr_t;

  // Sample memory
  sample_t ring [RING_DEPTH];

  // Control and fill state
  delay_t  string_delay;
  ptr_t    write_pointer;
  logic    wrapped;

  // Read stage
  logic    s1_valid;
  cmd_t    s1_cmd;
  sample_t s1_noise;
  ptr_t    s1_addr;
  sample_t rd_a, rd_b;
  logic    s1_fwd_a, s1_fwd_b;
  logic    s1_live_a, s1_live_b;
  sample_t s1_fwd_data;

  // Output register
  logic    out_valid;
  sample_t out_sample;

  logic        in_accept;
  logic        s1_advance;
  logic [DIFF_W-1:0] diff;
  ptr_t        addr_a, addr_b;
  sample_t     tap_a, tap_b, avg, wdata;

  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      string_delay <= '0;
    end else if (cfg_valid && cfg_ready) begin
      string_delay <= cfg_data;
    end
  end

  // Read addresses, wrapped to the ring
  assign diff   = DIFF_W'(write_pointer) - DIFF_W'(string_delay);
  assign addr_a = diff[PTR_W-1:0];
  assign addr_b = addr_a - ptr_t'(1);

  // Result path of the read stage
  assign tap_a = s1_fwd_a ? s1_fwd_data : (s1_live_a ? rd_a : '0);
  assign tap_b = s1_fwd_b ? s1_fwd_data : (s1_live_b ? rd_b : '0);
  assign avg   = avg_trunc({tap_a[SAMPLE_W-1], tap_a} + {tap_b[SAMPLE_W-1], tap_b});
  assign wdata = (s1_cmd == CMD_TICK) ? avg : s1_noise;

  // Handshakes
  assign s1_advance    = s1_valid && ((s1_cmd == CMD_EXCITE) || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_a <= ring[addr_a];
      rd_b <= ring[addr_b];
    end
    if (s1_advance) begin
      ring[s1_addr] <= wdata;
    end
  end

  // Pointer and fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      wrapped       <= 1'b0;
    end else if (in_accept) begin
      write_pointer <= write_pointer + ptr_t'(1);
      if (&write_pointer) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload, forwarding and fill flags
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd      <= cmd_t'(s_axis_tuser);
      s1_noise    <= sample_t'(s_axis_tdata);
      s1_addr     <= write_pointer;
      s1_fwd_a    <= s1_advance && (addr_a == s1_addr);
      s1_fwd_b    <= s1_advance && (addr_b == s1_addr);
      s1_live_a   <= wrapped || (addr_a < write_pointer);
      s1_live_b   <= wrapped || (addr_b < write_pointer);
      s1_fwd_data <= wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && (s1_cmd == CMD_TICK)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && (s1_cmd == CMD_TICK)) begin
      out_sample <= avg;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sample;

endmodule

### dv/pluck_checker.sv
// ----------------------------------------------------------------------------
// pluck_checker
// Watches the configuration, item and sample channels of the plucked-string
// synthesiser, keeps its own copy of the sample memory and write pointer, and
// compares every output sample with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pluck_checker #(
  parameter int RING_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  pssynth_pkg::delay_t  cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [15:0] noise_sample
  input  logic                 s_axis_tuser,  // [0] cmd
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,  // [15:0] out_sample
  output int                   mismatch_count,
  output int                   samples_owed
);
  import pssynth_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  // Shadow of the string memory and its pointer
  sample_t           ring_model [RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  delay_t            tap_delay;
  sample_t           pending_samples [$];
  int                errors = 0;

  // Averages two taps, halving toward zero
  function automatic sample_t string_average(sample_t a, sample_t b);
    int total;
    total = int'(a) + int'(b);
    return sample_t'(total / 2);
  endfunction

  // Works out the sample a tick gives from the current shadow state
  function automatic sample_t next_string_sample();
    logic [PTR_W-1:0] idx_a;
    logic [PTR_W-1:0] idx_b;
    idx_a = wr_ptr - PTR_W'(tap_delay);
    idx_b = idx_a - PTR_W'(1);
    return string_average(ring_model[idx_a], ring_model[idx_b]);
  endfunction

  // Sample at the pointer, then advance
  task automatic store_sample(sample_t value);
    ring_model[wr_ptr] = value;
    wr_ptr = wr_ptr + 1'b1;
  endtask

  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
      wr_ptr = '0;
      tap_delay = '0;
      pending_samples.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) tap_delay = cfg_data;

      // output sample transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected out_sample, expected none, got %0d", $time, got);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (got !== want) begin
            $display("%0t: out_sample expected %0d, got %0d", $time, want, got);
            errors++;
          end
        end
      end

      // item transaction: excite stores noise, tick predicts and stores
      if (s_axis_tvalid && s_axis_tready) begin
        if (cmd_t'(s_axis_tuser) == CMD_EXCITE) begin
          store_sample(sample_t'(s_axis_tdata));
        end else begin
          want = next_string_sample();
          pending_samples.push_back(want);
          store_sample(want);
        end
      end
    end
    mismatch_count <= errors;
    samples_owed   <= pending_samples.size();
  end

endmodule

### dv/plucked_string_delay_synth_test.sv
// ----------------------------------------------------------------------------
// plucked_string_delay_synth_test
// Drives excite and tick items into the plucked-string synthesiser under a
// range of delay settings, with random idling on both streams and one long
// output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plucked_string_delay_synth_test;
  import pssynth_pkg::*;

  localparam int RING_DEPTH   = 512;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 140;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  delay_t      cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] noise_sample
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] out_sample

  int          mismatch_count;
  int          samples_owed;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;        // no idling on either side
  bit          hold_off_req = 1'b0; // ask the sink for one long stall

  always #4 clk = ~clk;

  plucked_string_delay_synth #(.RING_DEPTH(RING_DEPTH)) dut (.*);

  pluck_checker #(.RING_DEPTH(RING_DEPTH)) pluck_check (.*);

  // Runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("plucked_string_delay_synth_test failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Noise with a bias toward the extremes
  function automatic sample_t pick_noise();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return -16'sd1;
      3:       return sample_t'($urandom_range(1));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sink side: random ready, with the long hold-off on request
  initial begin
    int stall;
    int burst;
    stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stall == 0 && burst == 0) begin
          stall = idle_len();
          burst = $urandom_range(24, 1);
        end
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          stall--;
        end else begin
          m_axis_tready <= 1'b1;
          burst--;
        end
      end
    end
  end

  // One item transaction, then an optional gap
  task automatic send_item(cmd_t kind, sample_t noise);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= noise;
    do @(posedge clk); while (!s_axis_tready);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted sample is out and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (samples_owed != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_delay(delay_t d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Plucks: a burst of excites followed by a decaying run of ticks, plus
  // some loose items mixed in
  task automatic pluck_phase(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(12, 1);
        repeat (len) send_item(CMD_EXCITE, pick_noise());
        sent += len;
        len = $urandom_range(40, 4);
        repeat (len) send_item(CMD_TICK, pick_noise());
        sent += len;
      end else begin
        len = $urandom_range(6, 1);
        repeat (len) send_item(cmd_t'($urandom_range(1)), pick_noise());
        sent += len;
      end
    end
  endtask

  initial begin
    delay_t delays [11];
    delays = '{9'd0, 9'd511, 9'd2, 9'd256, 9'd255, 9'd510, 9'd3,
               delay_t'($urandom), 9'd128, delay_t'($urandom), 9'd0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset delay of zero: the tap at the pointer sees the old entry
    send_item(CMD_TICK, 16'sh7FFF);
    send_item(CMD_EXCITE, 16'sh7FFF);
    send_item(CMD_EXCITE, 16'sh7FFF);
    send_item(CMD_TICK, pick_noise());
    send_item(CMD_EXCITE, 16'sh8000);

    // Delay of one: each tick averages the last two stored samples
    set_delay(9'd1);
    send_item(CMD_EXCITE, 16'sh7FFF);
    send_item(CMD_EXCITE, 16'sh7FFF);
    send_item(CMD_TICK, pick_noise());    // largest positive average
    send_item(CMD_EXCITE, 16'sh8000);
    send_item(CMD_EXCITE, 16'sh8000);
    send_item(CMD_TICK, pick_noise());    // most negative average
    send_item(CMD_EXCITE, -16'sd1);
    send_item(CMD_EXCITE, 16'sd0);
    send_item(CMD_TICK, pick_noise());    // negative odd sum rounds up to zero
    send_item(CMD_EXCITE, -16'sd3);
    send_item(CMD_EXCITE, 16'sd0);
    send_item(CMD_TICK, pick_noise());
    send_item(CMD_EXCITE, 16'sh7FFF);
    send_item(CMD_EXCITE, 16'sh8000);
    send_item(CMD_TICK, -16'sd1);
    send_item(CMD_TICK, 16'sh8000);       // tick fed by tick
    send_item(CMD_TICK, 16'sh7FFF);

    // Random phases over a spread of delays
    foreach (delays[i]) begin
      set_delay(delays[i]);
      quiet = (i % 4 == 1);
      if (i == 3) begin
        // back-to-back offers while the sink holds off
        quiet = 1'b1;
        hold_off_req = 1'b1;
      end
      pluck_phase(PHASE_ITEMS);
      drain();
      quiet = 1'b0;
    end

    drain();
    if (mismatch_count == 0 && samples_owed == 0) begin
      $display("plucked_string_delay_synth_test passed");
    end else begin
      $display("plucked_string_delay_synth_test failed");
    end
    $finish;
  end

endmodule
